// File: rtl/core/hrsp_pkg.sv
// Shared types, codes and match tables of the HTTP request stream parser.
// Used by hrsp_len_acc, hrsp_parse_fsm and http_request_stream_parser.
package hrsp_pkg;

  // Default width of the content-length accumulator
  localparam int LENGTH_BITS_DEF = 32;
  localparam int BODY_LEN_W      = 32;

  // Length of the "content-length" key
  localparam logic [3:0] KEY_LEN    = 4'd14;
  localparam logic [1:0] METHOD_LEN = 2'd3;

  // Byte constants
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Byte kind codes
  localparam logic [2:0] KIND_DROP    = 3'd0;
  localparam logic [2:0] KIND_METHOD  = 3'd1;
  localparam logic [2:0] KIND_URL     = 3'd2;
  localparam logic [2:0] KIND_VERSION = 3'd3;
  localparam logic [2:0] KIND_KEY     = 3'd4;
  localparam logic [2:0] KIND_VALUE   = 3'd5;
  localparam logic [2:0] KIND_BODY    = 3'd6;

  // Request status codes
  localparam logic [1:0] STAT_BUSY     = 2'd0;
  localparam logic [1:0] STAT_COMPLETE = 2'd1;
  localparam logic [1:0] STAT_BAD      = 2'd2;
  localparam logic [1:0] STAT_CLOSED   = 2'd3;

  // Parse phases
  typedef enum logic [3:0] {
    PH_METHOD     = 4'd0,
    PH_URL        = 4'd1,
    PH_VERSION    = 4'd2,
    PH_RL_LF      = 4'd3,
    PH_KEY        = 4'd4,
    PH_VALUE      = 4'd5,
    PH_HDR_LF     = 4'd6,
    PH_LINE_START = 4'd7,
    PH_END_LF     = 4'd8,
    PH_BODY       = 4'd9
  } phase_t;

  // One input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       conn_closed;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [2:0]            byte_kind;
    logic [7:0]            out_char;
    logic                  field_end;
    logic [1:0]            req_status;
    logic                  is_get;
    logic [BODY_LEN_W-1:0] body_length;
  } result_t;

  // Expected characters of "content-length"
  function automatic logic [7:0] key_char_at(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Expected characters of "get"
  function automatic logic [7:0] method_char_at(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h67; // g
      2'd1:    c = 8'h65; // e
      2'd2:    c = 8'h74; // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/hrsp_len_acc.sv
// Saturating decimal accumulator step for the content-length value.
// Depends on hrsp_pkg for the default accumulator width.
module hrsp_len_acc #(
  parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEF
) (
  input  logic [LENGTH_BITS-1:0] acc_in,
  input  logic [3:0]             digit,
  output logic [LENGTH_BITS-1:0] acc_out
);

  logic [LENGTH_BITS+3:0] sum;

  // Form acc*10 + digit as (acc<<3) + (acc<<1) + digit
  assign sum = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0} + {{LENGTH_BITS{1'b0}}, digit};

  // Saturate when the result no longer fits
  assign acc_out = (sum[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? {LENGTH_BITS{1'b1}}
                                                           : sum[LENGTH_BITS-1:0];

endmodule

// File: rtl/core/hrsp_parse_fsm.sv
// Per-request parse state and the per-byte state update and result logic.
// Depends on hrsp_pkg and hrsp_len_acc.
module hrsp_parse_fsm #(
  parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  hrsp_pkg::in_item_t item,
  output hrsp_pkg::result_t  res
);

  hrsp_pkg::phase_t       phase_r, phase_nxt;
  logic [1:0]             mpos_r, mpos_nxt;
  logic                   mmis_r, mmis_nxt;
  logic [3:0]             kpos_r, kpos_nxt;
  logic                   kmis_r, kmis_nxt;
  logic                   skip_r, skip_nxt;
  logic [LENGTH_BITS-1:0] pend_r, pend_nxt;
  logic                   dend_r, dend_nxt;
  logic [LENGTH_BITS-1:0] stored_r, stored_nxt;
  logic [LENGTH_BITS-1:0] remain_r, remain_nxt;

  logic [7:0]             raw;
  logic [7:0]             low;
  logic                   is_letter;
  logic                   is_digit;
  logic [LENGTH_BITS-1:0] pend_acc;
  logic [7:0]             digit_full;
  logic [LENGTH_BITS-1:0] remain_dec;
  logic [63:0]            stored_ext;
  logic [3:0]             kbase_pos;
  logic                   kbase_mis;
  logic [3:0]             kstep_pos;
  logic                   kstep_mis;
  logic                   kbase_fresh;

  // Fold the byte to lower case
  assign raw        = item.in_byte;
  assign low        = (raw >= hrsp_pkg::CH_UP_A && raw <= hrsp_pkg::CH_UP_Z) ?
                      raw + hrsp_pkg::CASE_OFS : raw;
  assign is_letter  = (low >= hrsp_pkg::CH_LO_A) && (low <= hrsp_pkg::CH_LO_Z);
  assign is_digit   = (low >= hrsp_pkg::CH_0) && (low <= hrsp_pkg::CH_9);
  assign digit_full = low - hrsp_pkg::CH_0;

  // Accumulate one decimal digit into the pending length
  hrsp_len_acc #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_len_acc (
    .acc_in  (pend_r),
    .digit   (digit_full[3:0]),
    .acc_out (pend_acc)
  );

  // Match one key character, from the current position or from a fresh line
  assign kbase_fresh = (phase_r == hrsp_pkg::PH_LINE_START);
  assign kbase_pos   = kbase_fresh ? 4'd0 : kpos_r;
  assign kbase_mis   = kbase_fresh ? 1'b0 : kmis_r;
  always_comb begin
    kstep_pos = kbase_pos;
    kstep_mis = kbase_mis;
    if (kbase_pos < hrsp_pkg::KEY_LEN && hrsp_pkg::key_char_at(kbase_pos) == low) begin
      kstep_pos = kbase_pos + 4'd1;
    end else begin
      kstep_mis = 1'b1;
    end
  end

  assign remain_dec = (remain_r != '0) ? remain_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1}
                                       : remain_r;
  assign stored_ext = 64'(stored_r);

  // Next state and result for one byte
  always_comb begin
    phase_nxt  = phase_r;
    mpos_nxt   = mpos_r;
    mmis_nxt   = mmis_r;
    kpos_nxt   = kpos_r;
    kmis_nxt   = kmis_r;
    skip_nxt   = skip_r;
    pend_nxt   = pend_r;
    dend_nxt   = dend_r;
    stored_nxt = stored_r;
    remain_nxt = remain_r;
    res        = '0;

    if (item.conn_closed) begin
      res.req_status = hrsp_pkg::STAT_CLOSED;
    end else begin
      res.out_char = (phase_r == hrsp_pkg::PH_URL || phase_r == hrsp_pkg::PH_BODY) ? raw : low;
      unique case (phase_r)
        hrsp_pkg::PH_METHOD: begin
          if (is_letter) begin
            res.byte_kind = hrsp_pkg::KIND_METHOD;
            if (mpos_r < hrsp_pkg::METHOD_LEN && hrsp_pkg::method_char_at(mpos_r) == low) begin
              mpos_nxt = mpos_r + 2'd1;
            end else begin
              mmis_nxt = 1'b1;
            end
          end else if (low == hrsp_pkg::CH_SPACE) begin
            res.field_end = 1'b1;
            phase_nxt     = hrsp_pkg::PH_URL;
          end
        end
        hrsp_pkg::PH_URL: begin
          if (raw == hrsp_pkg::CH_SPACE) begin
            res.field_end = 1'b1;
            phase_nxt     = hrsp_pkg::PH_VERSION;
          end else begin
            res.byte_kind = hrsp_pkg::KIND_URL;
          end
        end
        hrsp_pkg::PH_VERSION: begin
          if (low == hrsp_pkg::CH_CR) begin
            res.field_end = 1'b1;
            phase_nxt     = hrsp_pkg::PH_RL_LF;
          end else begin
            res.byte_kind = hrsp_pkg::KIND_VERSION;
          end
        end
        hrsp_pkg::PH_RL_LF: begin
          if (low == hrsp_pkg::CH_LF) begin
            kpos_nxt  = 4'd0;
            kmis_nxt  = 1'b0;
            skip_nxt  = 1'b1;
            phase_nxt = hrsp_pkg::PH_KEY;
          end else begin
            res.req_status = hrsp_pkg::STAT_BAD;
          end
        end
        hrsp_pkg::PH_KEY: begin
          priority if (low == hrsp_pkg::CH_COLON) begin
            res.field_end = 1'b1;
            skip_nxt      = 1'b1;
            pend_nxt      = '0;
            dend_nxt      = 1'b0;
            phase_nxt     = hrsp_pkg::PH_VALUE;
          end else if (skip_r && low == hrsp_pkg::CH_CR) begin
            phase_nxt = hrsp_pkg::PH_END_LF;
          end else if (!(skip_r && low == hrsp_pkg::CH_SPACE)) begin
            res.byte_kind = hrsp_pkg::KIND_KEY;
            skip_nxt      = 1'b0;
            kpos_nxt      = kstep_pos;
            kmis_nxt      = kstep_mis;
          end
        end
        hrsp_pkg::PH_VALUE: begin
          priority if (low == hrsp_pkg::CH_CR) begin
            res.field_end = 1'b1;
            phase_nxt     = hrsp_pkg::PH_HDR_LF;
          end else if (!(skip_r && low == hrsp_pkg::CH_SPACE)) begin
            res.byte_kind = hrsp_pkg::KIND_VALUE;
            skip_nxt      = 1'b0;
            if (!dend_r && is_digit) begin
              pend_nxt = pend_acc;
            end else begin
              dend_nxt = 1'b1;
            end
          end
        end
        hrsp_pkg::PH_HDR_LF: begin
          if (low == hrsp_pkg::CH_LF) begin
            if (!kmis_r && kpos_r == hrsp_pkg::KEY_LEN) begin
              stored_nxt = pend_r;
            end
            kpos_nxt  = 4'd0;
            kmis_nxt  = 1'b0;
            skip_nxt  = 1'b1;
            phase_nxt = hrsp_pkg::PH_LINE_START;
          end else begin
            res.req_status = hrsp_pkg::STAT_BAD;
          end
        end
        hrsp_pkg::PH_LINE_START: begin
          priority if (is_letter) begin
            res.byte_kind = hrsp_pkg::KIND_KEY;
            skip_nxt      = 1'b0;
            kpos_nxt      = kstep_pos;
            kmis_nxt      = kstep_mis;
            phase_nxt     = hrsp_pkg::PH_KEY;
          end else if (low == hrsp_pkg::CH_CR) begin
            phase_nxt = hrsp_pkg::PH_END_LF;
          end else begin
            res.req_status = hrsp_pkg::STAT_BAD;
          end
        end
        hrsp_pkg::PH_END_LF: begin
          priority if (low != hrsp_pkg::CH_LF) begin
            res.req_status = hrsp_pkg::STAT_BAD;
          end else if (stored_r == '0) begin
            res.req_status = hrsp_pkg::STAT_COMPLETE;
          end else begin
            remain_nxt = stored_r;
            phase_nxt  = hrsp_pkg::PH_BODY;
          end
        end
        default: begin
          // Body bytes: count down to the end of the body
          res.byte_kind = hrsp_pkg::KIND_BODY;
          remain_nxt    = remain_dec;
          if (remain_dec == '0) begin
            res.field_end  = 1'b1;
            res.req_status = hrsp_pkg::STAT_COMPLETE;
          end
        end
      endcase

      // Report method and length on completion
      if (res.req_status == hrsp_pkg::STAT_COMPLETE) begin
        res.is_get      = !mmis_r && (mpos_r == hrsp_pkg::METHOD_LEN);
        res.body_length = stored_ext[hrsp_pkg::BODY_LEN_W-1:0];
      end
    end

    // Start a new request after any final status
    if (res.req_status != hrsp_pkg::STAT_BUSY) begin
      phase_nxt  = hrsp_pkg::PH_METHOD;
      mpos_nxt   = 2'd0;
      mmis_nxt   = 1'b0;
      kpos_nxt   = 4'd0;
      kmis_nxt   = 1'b0;
      skip_nxt   = 1'b1;
      pend_nxt   = '0;
      dend_nxt   = 1'b0;
      stored_nxt = '0;
      remain_nxt = '0;
    end
  end

  // Hold the parse state; advance on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= hrsp_pkg::PH_METHOD;
      mpos_r   <= 2'd0;
      mmis_r   <= 1'b0;
      kpos_r   <= 4'd0;
      kmis_r   <= 1'b0;
      skip_r   <= 1'b1;
      pend_r   <= '0;
      dend_r   <= 1'b0;
      stored_r <= '0;
      remain_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      mpos_r   <= mpos_nxt;
      mmis_r   <= mmis_nxt;
      kpos_r   <= kpos_nxt;
      kmis_r   <= kmis_nxt;
      skip_r   <= skip_nxt;
      pend_r   <= pend_nxt;
      dend_r   <= dend_nxt;
      stored_r <= stored_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

// File: rtl/core/http_request_stream_parser.sv
// HTTP request stream parser: input register, per-byte parse step, result register.
// The accepted item waits in the input register; the result register loads when the parser steps.
// One item per cycle while out_stall is low; an output stall holds the input via in_stall.
// Reset: synchronous active-low rst_n empties both registers and puts the parser
// at the start of a request (method phase, no stored length).
module http_request_stream_parser #(
  parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_conn_closed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_byte_kind,
  output logic [7:0]  out_char,
  output logic        out_field_end,
  output logic [1:0]  out_req_status,
  output logic        out_is_get,
  output logic [31:0] out_body_length
);

  logic               in_v_r, in_v_nxt;
  hrsp_pkg::in_item_t in_item_r;
  logic               out_v_r, out_v_nxt;
  hrsp_pkg::result_t  res_r;
  hrsp_pkg::result_t  res_c;
  logic               adv;
  logic               in_acc;
  logic               step;

  // Pipeline handshake
  assign adv      = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign step     = in_v_r && adv;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_acc) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = adv ? in_v_r : out_v_r;
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.in_byte     <= in_byte;
      in_item_r.conn_closed <= in_conn_closed;
    end
    if (step) begin
      res_r <= res_c;
    end
  end

  // Parse one byte per processed item
  hrsp_parse_fsm #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .res   (res_c)
  );

  assign out_valid       = out_v_r;
  assign out_byte_kind   = res_r.byte_kind;
  assign out_char        = res_r.out_char;
  assign out_field_end   = res_r.field_end;
  assign out_req_status  = res_r.req_status;
  assign out_is_get      = res_r.is_get;
  assign out_body_length = res_r.body_length;

  // Method and length are reported only with a completed request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_req_status != hrsp_pkg::STAT_COMPLETE) |->
      !out_is_get && (out_body_length == 32'd0))
    else $error("is_get or body_length set without completion");

  // A closure result carries no byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_req_status == hrsp_pkg::STAT_CLOSED) |->
      (out_byte_kind == hrsp_pkg::KIND_DROP) && (out_char == 8'd0) && !out_field_end)
    else $error("closure result carries byte data");

  // The last body byte completes the request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_kind == hrsp_pkg::KIND_BODY) && out_field_end |->
      (out_req_status == hrsp_pkg::STAT_COMPLETE))
    else $error("body end without completion");

  // A processed item always produces a result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("processed item lost");

endmodule

// File: tb/tb_http_request_stream_parser.sv
// Testbench of http_request_stream_parser: sends request bytes and closures,
// predicts every result with its own parser model and checks it field by field.
// Depends on hrsp_pkg and the parser RTL.
module tb_http_request_stream_parser;

  localparam int              ITEM_TARGET = 1700;
  localparam int              HOLD_CYCLES = 64;
  localparam logic [31:0]     LEN_SAT     = 32'hFFFF_FFFF;
  localparam logic [8*14-1:0] KEY_TEXT    = "content-length";
  localparam logic [8*3-1:0]  GET_TEXT    = "get";

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_conn_closed;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_byte_kind;
  logic [7:0]  out_char;
  logic        out_field_end;
  logic [1:0]  out_req_status;
  logic        out_is_get;
  logic [31:0] out_body_length;

  // Parser state as the predictor sees it
  hrsp_pkg::phase_t parse_ph;
  logic [1:0]       get_pos;
  logic             get_miss;
  logic [3:0]       key_pos;
  logic             key_miss;
  logic             skip_space;
  logic [31:0]      value_len;
  logic             value_digits_done;
  logic [31:0]      content_len;
  logic [31:0]      body_left;

  hrsp_pkg::result_t expected_q[$];
  hrsp_pkg::result_t want_res;
  int          errors     = 0;
  int          items_sent = 0;
  bit          calm       = 1'b0;
  int          hold_req   = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;

  http_request_stream_parser i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_conn_closed (in_conn_closed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_kind  (out_byte_kind),
    .out_char       (out_char),
    .out_field_end  (out_field_end),
    .out_req_status (out_req_status),
    .out_is_get     (out_is_get),
    .out_body_length(out_body_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up after a generous bound
  initial begin
    #2000000;
    $display("tb_http_request_stream_parser failed");
    $finish;
  end

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= hrsp_pkg::CH_UP_A && c <= hrsp_pkg::CH_UP_Z) ? c + hrsp_pkg::CASE_OFS : c;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c >= hrsp_pkg::CH_LO_A && c <= hrsp_pkg::CH_LO_Z;
  endfunction

  function automatic logic [7:0] other_byte(input logic [7:0] avoid);
    logic [7:0] c;
    c = 8'($urandom);
    return (c == avoid) ? ~avoid : c;
  endfunction

  function automatic void start_request();
    parse_ph          = hrsp_pkg::PH_METHOD;
    get_pos           = '0;
    get_miss          = 1'b0;
    key_pos           = '0;
    key_miss          = 1'b0;
    skip_space        = 1'b1;
    value_len         = '0;
    value_digits_done = 1'b0;
    content_len       = '0;
    body_left         = '0;
  endfunction

  function automatic void key_reset();
    key_pos    = '0;
    key_miss   = 1'b0;
    skip_space = 1'b1;
  endfunction

  // Advance the match against "content-length"
  function automatic void key_step(input logic [7:0] c);
    if (key_pos < hrsp_pkg::KEY_LEN && KEY_TEXT[8*(13-int'(key_pos)) +: 8] == c) key_pos++;
    else key_miss = 1'b1;
  endfunction

  // Work out the result of one accepted item and queue it
  function automatic void predict_result(input logic [7:0] b, input logic closed);
    hrsp_pkg::result_t r;
    logic [7:0]        low;
    logic [31:0]       d;
    r = '0;
    low = fold_case(b);
    if (closed) begin
      start_request();
      r.req_status = hrsp_pkg::STAT_CLOSED;
    end else begin
      r.out_char = (parse_ph == hrsp_pkg::PH_URL || parse_ph == hrsp_pkg::PH_BODY) ? b : low;
      case (parse_ph)
        hrsp_pkg::PH_METHOD: begin
          if (is_letter(low)) begin
            r.byte_kind = hrsp_pkg::KIND_METHOD;
            if (get_pos < hrsp_pkg::METHOD_LEN &&
                GET_TEXT[8*(2-int'(get_pos)) +: 8] == low) get_pos++;
            else get_miss = 1'b1;
          end else if (low == hrsp_pkg::CH_SPACE) begin
            r.field_end = 1'b1;
            parse_ph = hrsp_pkg::PH_URL;
          end
        end
        hrsp_pkg::PH_URL: begin
          if (b == hrsp_pkg::CH_SPACE) begin
            r.field_end = 1'b1;
            parse_ph = hrsp_pkg::PH_VERSION;
          end else r.byte_kind = hrsp_pkg::KIND_URL;
        end
        hrsp_pkg::PH_VERSION: begin
          if (low == hrsp_pkg::CH_CR) begin
            r.field_end = 1'b1;
            parse_ph = hrsp_pkg::PH_RL_LF;
          end else r.byte_kind = hrsp_pkg::KIND_VERSION;
        end
        hrsp_pkg::PH_RL_LF: begin
          if (low == hrsp_pkg::CH_LF) begin
            key_reset();
            parse_ph = hrsp_pkg::PH_KEY;
          end else r.req_status = hrsp_pkg::STAT_BAD;
        end
        hrsp_pkg::PH_KEY: begin
          if (low == hrsp_pkg::CH_COLON) begin
            r.field_end = 1'b1;
            skip_space = 1'b1;
            value_len = '0;
            value_digits_done = 1'b0;
            parse_ph = hrsp_pkg::PH_VALUE;
          end else if (skip_space && low == hrsp_pkg::CH_CR) begin
            parse_ph = hrsp_pkg::PH_END_LF;
          end else if (!(skip_space && low == hrsp_pkg::CH_SPACE)) begin
            r.byte_kind = hrsp_pkg::KIND_KEY;
            skip_space = 1'b0;
            key_step(low);
          end
        end
        hrsp_pkg::PH_VALUE: begin
          if (low == hrsp_pkg::CH_CR) begin
            r.field_end = 1'b1;
            parse_ph = hrsp_pkg::PH_HDR_LF;
          end else if (!(skip_space && low == hrsp_pkg::CH_SPACE)) begin
            r.byte_kind = hrsp_pkg::KIND_VALUE;
            skip_space = 1'b0;
            // Accumulate leading digits, saturating
            if (!value_digits_done && low >= hrsp_pkg::CH_0 && low <= hrsp_pkg::CH_9) begin
              d = 32'(low - hrsp_pkg::CH_0);
              if (value_len > (LEN_SAT - d) / 10) value_len = LEN_SAT;
              else value_len = value_len * 10 + d;
            end else value_digits_done = 1'b1;
          end
        end
        hrsp_pkg::PH_HDR_LF: begin
          if (low == hrsp_pkg::CH_LF) begin
            if (!key_miss && key_pos == hrsp_pkg::KEY_LEN) content_len = value_len;
            key_reset();
            parse_ph = hrsp_pkg::PH_LINE_START;
          end else r.req_status = hrsp_pkg::STAT_BAD;
        end
        hrsp_pkg::PH_LINE_START: begin
          if (is_letter(low)) begin
            r.byte_kind = hrsp_pkg::KIND_KEY;
            key_reset();
            skip_space = 1'b0;
            key_step(low);
            parse_ph = hrsp_pkg::PH_KEY;
          end else if (low == hrsp_pkg::CH_CR) begin
            parse_ph = hrsp_pkg::PH_END_LF;
          end else r.req_status = hrsp_pkg::STAT_BAD;
        end
        hrsp_pkg::PH_END_LF: begin
          if (low != hrsp_pkg::CH_LF) r.req_status = hrsp_pkg::STAT_BAD;
          else if (content_len == 0) r.req_status = hrsp_pkg::STAT_COMPLETE;
          else begin
            body_left = content_len;
            parse_ph = hrsp_pkg::PH_BODY;
          end
        end
        default: begin
          r.byte_kind = hrsp_pkg::KIND_BODY;
          if (body_left > 0) body_left--;
          if (body_left == 0) begin
            r.field_end = 1'b1;
            r.req_status = hrsp_pkg::STAT_COMPLETE;
          end
        end
      endcase
      if (r.req_status == hrsp_pkg::STAT_COMPLETE) begin
        r.is_get = !get_miss && get_pos == hrsp_pkg::METHOD_LEN;
        r.body_length = content_len;
      end
      if (r.req_status != hrsp_pkg::STAT_BUSY) start_request();
    end
    expected_q.push_back(r);
  endfunction

  // Offer one item from a falling edge until it is taken, then return at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic closed);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      in_byte = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    in_conn_closed = closed;
    do @(posedge clk); while (in_stall);
    predict_result(b, closed);
    items_sent++;
    @(negedge clk);
  endtask

  // Send a string, optionally with letters in random case
  task automatic send_text(input string s, input bit mix);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && is_letter(c) && $urandom_range(1) == 1) c = c - hrsp_pkg::CASE_OFS;
      send_byte(c, 1'b0);
    end
  endtask

  // Send CR and then LF, or now and then a wrong byte in place of the LF
  task automatic send_crlf(input int break_pct, output bit broken);
    send_byte(hrsp_pkg::CH_CR, 1'b0);
    broken = $urandom_range(99) < break_pct;
    send_byte(broken ? other_byte(hrsp_pkg::CH_LF) : hrsp_pkg::CH_LF, 1'b0);
  endtask

  // Stop offering items and wait for every expected result
  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // One mostly well-formed request with random content
  task automatic send_request();
    int         headers;
    bit         broken;
    logic [7:0] c;
    case ($urandom_range(5))
      0, 1:    send_text("get", 1'b1);
      2:       send_text("post", 1'b1);
      3:       send_text("ge", 1'b1);
      4:       send_text("gets", 1'b1);
      default: repeat ($urandom_range(1, 5)) send_byte(other_byte(hrsp_pkg::CH_SPACE), 1'b0);
    endcase
    send_byte(hrsp_pkg::CH_SPACE, 1'b0);
    repeat ($urandom_range(0, 8)) send_byte(other_byte(hrsp_pkg::CH_SPACE), 1'b0);
    send_byte(hrsp_pkg::CH_SPACE, 1'b0);
    if ($urandom_range(3) != 0) send_text("HTTP/1.0", 1'b0);
    else repeat ($urandom_range(0, 6)) send_byte(other_byte(hrsp_pkg::CH_CR), 1'b0);
    send_crlf(8, broken);
    if (broken) return;
    repeat ($urandom_range(0, 2)) send_byte(hrsp_pkg::CH_SPACE, 1'b0);
    headers = $urandom_range(0, 3);
    for (int h = 0; h < headers; h++) begin
      // Start a later line with a byte that is neither a letter nor CR
      if (h > 0 && $urandom_range(99) < 5) begin
        c = 8'($urandom);
        if (is_letter(fold_case(c)) || c == hrsp_pkg::CH_CR) c = hrsp_pkg::CH_0;
        send_byte(c, 1'b0);
        return;
      end
      case ($urandom_range(5))
        0, 1, 2: send_text("content-length", 1'b1);
        3:       send_text("content-lengthx", 1'b1);
        4:       send_text("content", 1'b1);
        default: begin
          repeat ($urandom_range(1, 6))
            send_byte(8'(hrsp_pkg::CH_LO_A + $urandom_range(25)), 1'b0);
        end
      endcase
      send_byte(hrsp_pkg::CH_COLON, 1'b0);
      repeat ($urandom_range(0, 2)) send_byte(hrsp_pkg::CH_SPACE, 1'b0);
      case ($urandom_range(9))
        0: ;
        1, 2, 3, 4, 5: send_text($sformatf("%0d", $urandom_range(0, 40)), 1'b0);
        6: send_text("4294967295", 1'b0);
        7: repeat ($urandom_range(10, 14)) send_byte(8'(hrsp_pkg::CH_0 + $urandom_range(9)), 1'b0);
        8: begin
          send_text($sformatf("%0d", $urandom_range(0, 9)), 1'b0);
          send_text("x 7", 1'b1);
        end
        default: send_text("abc 12", 1'b1);
      endcase
      send_crlf(5, broken);
      if (broken) return;
    end
    send_crlf(5, broken);
    if (broken) return;
    // Send the body, or cut a huge one short with a closure
    if (parse_ph == hrsp_pkg::PH_BODY) begin
      if (body_left <= 48) begin
        repeat (body_left) send_byte(8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
    end
  endtask

  task automatic test_directed();
    // Mixed-case get, dropped byte, URL 0xFF, empty version, empty header block
    send_text("GeT", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(hrsp_pkg::CH_SPACE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(hrsp_pkg::CH_SPACE, 1'b0);
    send_byte(hrsp_pkg::CH_CR, 1'b0);
    send_byte(hrsp_pkg::CH_LF, 1'b0);
    send_byte(hrsp_pkg::CH_CR, 1'b0);
    send_byte(hrsp_pkg::CH_LF, 1'b0);
    // Closure between requests
    send_byte(8'hFF, 1'b1);
    // Missing LF after the request line
    send_text("x  ", 1'b0);
    send_byte(hrsp_pkg::CH_CR, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    repeat (6) send_request();
    calm = 1'b0;
  endtask

  task automatic test_stall_fill();
    hold_req++;
    repeat (3) send_request();
  endtask

  task automatic test_pause_drain();
    send_request();
    wait_drained();
    send_request();
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int pick;
    stop_at = ITEM_TARGET;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 80) send_request();
      else if (pick < 92) begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(19) == 0);
      end else send_byte(8'($urandom), 1'b1);
    end
  endtask

  // Receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 27);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual kind %0h char %0h",
                 $time, out_byte_kind, out_char);
      end else begin
        want_res = expected_q.pop_front();
        check_field("byte_kind", 32'(want_res.byte_kind), 32'(out_byte_kind));
        check_field("out_char", 32'(want_res.out_char), 32'(out_char));
        check_field("field_end", 32'(want_res.field_end), 32'(out_field_end));
        check_field("req_status", 32'(want_res.req_status), 32'(out_req_status));
        check_field("is_get", 32'(want_res.is_get), 32'(out_is_get));
        check_field("body_length", want_res.body_length, out_body_length);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_conn_closed = 1'b0;
    start_request();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_steady_stream();
    test_stall_fill();
    test_pause_drain();
    test_random_traffic();

    // Drain and let the pipeline settle
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_http_request_stream_parser passed");
    end else begin
      $display("tb_http_request_stream_parser failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/hrsp_pkg.sv
rtl/core/hrsp_len_acc.sv
rtl/core/hrsp_parse_fsm.sv
rtl/core/http_request_stream_parser.sv
tb/tb_http_request_stream_parser.sv
